// File: src/task_execution_time_monitor_defines.svh
// assertion helpers used by the checker file
`ifndef TASK_EXECUTION_TIME_MONITOR_DEFINES_SVH
`define TASK_EXECUTION_TIME_MONITOR_DEFINES_SVH

// property checked at every clock edge outside reset
`define TETM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define TETM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/tetm_pkg.sv
`timescale 1ns / 1ps

package tetm_pkg;

	localparam int TASK_W  = 8;
	localparam int STAMP_W = 32;
	localparam int US_W    = 32;
	localparam int CLK_W   = 30;
	localparam int SCALE_W = 20;
	localparam int PROD_W  = STAMP_W + SCALE_W;

	localparam logic [SCALE_W-1:0] US_PER_SEC     = SCALE_W'(1000000);
	localparam logic [CLK_W-1:0]   CLOCK_HZ_RESET = CLK_W'(168000000);

	typedef enum logic [1:0] {
		FUNC_START = 2'd0,
		FUNC_STOP  = 2'd1,
		FUNC_READ  = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_MULT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_DELIVER
	} state_t;

	typedef struct packed {
		logic [STAMP_W-1:0] start;
		logic [US_W-1:0]    latest;
		logic [US_W-1:0]    peak;
	} row_t;

	typedef struct packed {
		logic              go;
		logic [PROD_W-1:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [US_W-1:0] quotient;
	} div_rsp_t;

endpackage

// File: src/tetm_div.sv
`timescale 1ns / 1ps

module tetm_div import tetm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	input  logic [CLK_W-1:0] divisor,
	output div_rsp_t         rsp
);

	localparam int CNT_W = $clog2(US_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CLK_W-1:0]  rem_q;
	logic [US_W-1:0]   quo_q;

	logic [CLK_W:0]    trial;
	logic              ge;
	logic [CLK_W:0]    diff;
	logic              sat;

	// quotient overflows 32 bits exactly when the upper dividend part reaches the divisor
	assign sat   = {{(CLK_W-(PROD_W-US_W)){1'b0}}, req.dividend[PROD_W-1:US_W]} >= divisor;
	assign trial = {rem_q, quo_q[US_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= !sat;
				done_q <= sat;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(US_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one restoring step per cycle, quotient bits shift in as dividend bits shift out
	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= {{(CLK_W-(PROD_W-US_W)){1'b0}}, req.dividend[PROD_W-1:US_W]};
			quo_q <= sat ? '1 : req.dividend[US_W-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[CLK_W-1:0] : trial[CLK_W-1:0];
			quo_q <= {quo_q[US_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// File: src/task_execution_time_monitor.sv
`timescale 1ns / 1ps
// per-task run time monitor
// item channel: item_valid/item_stall with func, task_id, cycle_stamp; one word at a time,
//   item_stall stays high from the accepting edge until the result is handed to the
//   output register
// result channel: result_valid/result_stall with task_number, latest_us, peak_us, ignored;
//   exactly one result word per item, held in an output register so a new item is taken
//   while a result still waits
// flow: start, read and out-of-range items go from lookup straight to delivery;
//   stop items pass table read, subtract, multiply and a 32-step divider that skips
//   its steps when the time saturates
// a new item is taken only after the last one reaches the output register; stops also wait on
//   the serial divider that converts cycles to microseconds one quotient bit per cycle
// clock_hz_we/clock_hz_wdata write the clock frequency; write it only while idle
// reset: clock_hz returns to 168 MHz and every task row reads as zero through per-row
//   valid flags, no clearing pass is needed
// a stalled result word holds; the block finishes the current item and then waits
//   in its delivery state until the output register frees up
module task_execution_time_monitor import tetm_pkg::*; #(
	parameter int TASK_COUNT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clock_hz_we,
	input  logic [CLK_W-1:0]   clock_hz_wdata,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         func,
	input  logic [TASK_W-1:0]  task_id,
	input  logic [STAMP_W-1:0] cycle_stamp,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [TASK_W-1:0]  task_number,
	output logic [US_W-1:0]    latest_us,
	output logic [US_W-1:0]    peak_us,
	output logic               ignored
);

	localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
	localparam int LIM_W = TASK_W + 1;
	localparam logic [LIM_W-1:0] TASK_LIMIT = LIM_W'(TASK_COUNT);

	state_t state_q, state_d;

	logic [CLK_W-1:0]   clock_hz_q;
	logic               item_acc;
	logic               in_range;
	logic [IDX_W-1:0]   rd_idx;
	logic [IDX_W-1:0]   wr_idx;

	func_t              func_q;
	logic [TASK_W-1:0]  task_q;
	logic [STAMP_W-1:0] stamp_q;
	logic               ign_q;

	row_t               mem [TASK_COUNT];
	logic [TASK_COUNT-1:0] row_vld_q;
	row_t               rd_row_q;
	logic               rd_hit_q;
	row_t               lookup_row;
	row_t               row_q;

	logic [STAMP_W-1:0] elapsed_q;
	logic [PROD_W-1:0]  prod_q;

	logic               wr_en;
	row_t               wr_row;
	logic               res_ld;
	logic [US_W-1:0]    res_latest_d;
	logic [US_W-1:0]    res_peak_d;
	logic               res_ign_d;
	logic [US_W-1:0]    res_latest_q;
	logic [US_W-1:0]    res_peak_q;
	logic               res_ign_q;
	logic               out_ld;
	logic [US_W-1:0]    new_peak;

	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign in_range   = {1'b0, task_id} < TASK_LIMIT;
	assign rd_idx     = task_id[IDX_W-1:0];
	assign wr_idx     = task_q[IDX_W-1:0];
	assign lookup_row = rd_hit_q ? rd_row_q : '0;
	assign new_peak   = (div_rsp.quotient > row_q.peak) ? div_rsp.quotient : row_q.peak;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= CLOCK_HZ_RESET;
		end else if (clock_hz_we) begin
			clock_hz_q <= clock_hz_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		wr_en        = 1'b0;
		wr_row       = lookup_row;
		res_ld       = 1'b0;
		res_latest_d = lookup_row.latest;
		res_peak_d   = lookup_row.peak;
		res_ign_d    = 1'b0;
		div_req.go       = 1'b0;
		div_req.dividend = prod_q;
		out_ld       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_acc) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (ign_q) begin
					res_ld       = 1'b1;
					res_latest_d = '0;
					res_peak_d   = '0;
					res_ign_d    = 1'b1;
					state_d      = ST_DELIVER;
				end else begin
					case (func_q)
						FUNC_START: begin
							wr_en        = 1'b1;
							wr_row.start = stamp_q;
							res_ld       = 1'b1;
							state_d      = ST_DELIVER;
						end
						FUNC_STOP: begin
							state_d = ST_MULT;
						end
						default: begin
							// read, and the unused code behaves the same
							res_ld  = 1'b1;
							state_d = ST_DELIVER;
						end
					endcase
				end
			end
			ST_MULT: begin
				state_d = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				div_req.go = 1'b1;
				state_d    = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					wr_en         = 1'b1;
					wr_row.start  = row_q.start;
					wr_row.latest = div_rsp.quotient;
					wr_row.peak   = new_peak;
					res_ld        = 1'b1;
					res_latest_d  = div_rsp.quotient;
					res_peak_d    = new_peak;
					state_d       = ST_DELIVER;
				end
			end
			ST_DELIVER: begin
				if (!result_valid || !result_stall) begin
					out_ld  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// task table, one row per task, registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_idx] <= wr_row;
		if (item_acc && in_range) rd_row_q <= mem[rd_idx];
	end

	// rows never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_hit_q  <= 1'b0;
		end else begin
			if (wr_en) row_vld_q[wr_idx] <= 1'b1;
			if (item_acc) rd_hit_q <= in_range && row_vld_q[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			func_q  <= func_t'(func);
			task_q  <= task_id;
			stamp_q <= cycle_stamp;
			ign_q   <= !in_range;
		end
		if (state_q == ST_LOOKUP) begin
			row_q     <= lookup_row;
			elapsed_q <= stamp_q - lookup_row.start;
		end
		if (state_q == ST_MULT) begin
			prod_q <= PROD_W'(elapsed_q) * PROD_W'(US_PER_SEC);
		end
		if (res_ld) begin
			res_latest_q <= res_latest_d;
			res_peak_q   <= res_peak_d;
			res_ign_q    <= res_ign_d;
		end
	end

	tetm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.divisor (clock_hz_q),
		.rsp     (div_rsp)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_ld) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			task_number <= task_q;
			latest_us   <= res_latest_q;
			peak_us     <= res_peak_q;
			ignored     <= res_ign_q;
		end
	end

endmodule

// File: src/tetm_checker.sv
`timescale 1ns / 1ps
`include "task_execution_time_monitor_defines.svh"

module tetm_checker import tetm_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input logic               result_valid,
	input logic               result_stall,
	input logic [US_W-1:0]    latest_us,
	input logic [US_W-1:0]    peak_us,
	input logic               ignored
);

	// one item in flight: the input side closes right after an accept
	`TETM_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "accepted word did not close the input")

	// an ignored task reports zero times
	`TETM_ASSERT(a_ignored_zero, !(result_valid && ignored) || (latest_us == 0 && peak_us == 0), "ignored word carries nonzero times")

	// the peak never falls below the latest time
	`TETM_ASSERT(a_peak_ge_latest, !result_valid || (peak_us >= latest_us), "peak time below latest time")

	// a stalled result word holds
	`TETM_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(latest_us) && $stable(peak_us), "stalled result word changed")

endmodule

bind task_execution_time_monitor tetm_checker u_tetm_checker (.*);

// File: test/task_execution_time_monitor_checker.sv
`timescale 1ns / 1ps

module task_execution_time_monitor_checker import tetm_pkg::*; #(
	parameter int TASK_COUNT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clock_hz_we,
	input  logic [CLK_W-1:0]   clock_hz_wdata,
	input  logic               item_valid,
	input  logic               item_stall,
	input  logic [1:0]         func,
	input  logic [TASK_W-1:0]  task_id,
	input  logic [STAMP_W-1:0] cycle_stamp,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic [TASK_W-1:0]  task_number,
	input  logic [US_W-1:0]    latest_us,
	input  logic [US_W-1:0]    peak_us,
	input  logic               ignored,
	output int                 mismatches,
	output int                 pending,
	output int                 results_seen
);

	typedef struct packed {
		logic [TASK_W-1:0] task_number;
		logic [US_W-1:0]   latest;
		logic [US_W-1:0]   peak;
		logic              ignored;
	} timing_t;

	localparam logic [63:0] MICROS_PER_SEC = 64'd1000000;

	timing_t            due_q[$];
	timing_t            want;
	logic [STAMP_W-1:0] started_at [TASK_COUNT];
	logic [US_W-1:0]    last_run [TASK_COUNT];
	logic [US_W-1:0]    worst_run [TASK_COUNT];
	logic [CLK_W-1:0]   core_hz;
	int                 bad_count;
	int                 seen_count;

	// floor(cycles * 1e6 / hz), saturating on a zero clock or a quotient past 32 bits
	function automatic logic [US_W-1:0] cycles_as_us(logic [STAMP_W-1:0] cycles,
			logic [CLK_W-1:0] hz);
		logic [63:0] scaled;
		if (hz == '0)
			return '1;
		scaled = (64'(cycles) * MICROS_PER_SEC) / 64'(hz);
		if (scaled[63:32] != '0)
			return '1;
		return scaled[US_W-1:0];
	endfunction

	function automatic timing_t predict_timing(logic [1:0] op, logic [TASK_W-1:0] id,
			logic [STAMP_W-1:0] stamp);
		timing_t        r;
		logic [US_W-1:0] run;
		r.task_number = id;
		if (id >= TASK_COUNT) begin
			r.latest  = '0;
			r.peak    = '0;
			r.ignored = 1'b1;
			return r;
		end
		case (op)
			FUNC_START: begin
				started_at[id] = stamp;
			end
			FUNC_STOP: begin
				run = cycles_as_us(stamp - started_at[id], core_hz);
				last_run[id] = run;
				if (run > worst_run[id])
					worst_run[id] = run;
			end
			default: begin
			end
		endcase
		r.latest  = last_run[id];
		r.peak    = worst_run[id];
		r.ignored = 1'b0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_COUNT; i++) begin
				started_at[i] = '0;
				last_run[i]   = '0;
				worst_run[i]  = '0;
			end
			core_hz = CLOCK_HZ_RESET;
			due_q.delete();
			bad_count  = 0;
			seen_count = 0;
			mismatches   <= 0;
			pending      <= 0;
			results_seen <= 0;
		end else begin
			if (clock_hz_we)
				core_hz = clock_hz_wdata;
			if (result_valid && !result_stall) begin
				seen_count++;
				if (due_q.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("unexpected result word: task %0d latest %0d peak %0d ignored %0b",
							task_number, latest_us, peak_us, ignored);
				end else begin
					want = due_q.pop_front();
					if (want.task_number !== task_number || want.latest !== latest_us ||
							want.peak !== peak_us || want.ignored !== ignored) begin
						bad_count++;
						if (bad_count <= 10) begin
							$write("mismatch: expected task %0d latest %0d peak %0d ignored %0b,",
								want.task_number, want.latest, want.peak, want.ignored);
							$display(" got task %0d latest %0d peak %0d ignored %0b",
								task_number, latest_us, peak_us, ignored);
						end
					end
				end
			end
			if (item_valid && !item_stall)
				due_q.push_back(predict_timing(func, task_id, cycle_stamp));
			mismatches   <= bad_count;
			pending      <= due_q.size();
			results_seen <= seen_count;
		end
	end

endmodule

// File: test/task_execution_time_monitor_tb.sv
`timescale 1ns / 1ps

module task_execution_time_monitor_tb;
	import tetm_pkg::*;

	localparam int         TASK_COUNT  = 16;
	localparam logic [1:0] FUNC_SPARE  = 2'd3;
	localparam int         WAIT_MAX    = 7;
	localparam int         LONG_HOLD   = 300;
	localparam int         SETTLE      = 50;
	localparam int         PHASE_WORDS = 100;
	localparam int         PLAN_LEN    = 9;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               clock_hz_we;
	logic [CLK_W-1:0]   clock_hz_wdata;
	logic               item_valid;
	logic               item_stall;
	logic [1:0]         func;
	logic [TASK_W-1:0]  task_id;
	logic [STAMP_W-1:0] cycle_stamp;
	logic               result_valid;
	logic               result_stall;
	logic [TASK_W-1:0]  task_number;
	logic [US_W-1:0]    latest_us;
	logic [US_W-1:0]    peak_us;
	logic               ignored;

	int mismatches;
	int pending;
	int results_seen;

	bit                 idle_on = 1'b1;
	int                 hold_asks = 0;
	int                 hold_served = 0;
	int                 words_sent = 0;
	int                 stop_words = 0;
	int                 ignored_words = 0;
	int                 settings_used = 1;
	logic [STAMP_W-1:0] opened_at [256];
	logic [CLK_W-1:0]   clock_plan [PLAN_LEN];

	task_execution_time_monitor #(.TASK_COUNT(TASK_COUNT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.clock_hz_we(clock_hz_we),
		.clock_hz_wdata(clock_hz_wdata),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.func(func),
		.task_id(task_id),
		.cycle_stamp(cycle_stamp),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.task_number(task_number),
		.latest_us(latest_us),
		.peak_us(peak_us),
		.ignored(ignored)
	);

	task_execution_time_monitor_checker #(.TASK_COUNT(TASK_COUNT)) scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.clock_hz_we(clock_hz_we),
		.clock_hz_wdata(clock_hz_wdata),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.func(func),
		.task_id(task_id),
		.cycle_stamp(cycle_stamp),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.task_number(task_number),
		.latest_us(latest_us),
		.peak_us(peak_us),
		.ignored(ignored),
		.mismatches(mismatches),
		.pending(pending),
		.results_seen(results_seen)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("run timed out with %0d results outstanding", pending);
		$display("status: fail");
		$finish;
	end

	// result side: random hold-off after each accepted word while idle_on is set, plus one long one on request
	initial begin
		int stall_left;
		stall_left = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall)
				stall_left = idle_on ? $urandom_range(0, WAIT_MAX) : 0;
			if (hold_served != hold_asks) begin
				hold_served = hold_asks;
				stall_left = LONG_HOLD;
			end
			result_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// entered and left right after a rising edge
	task automatic offer_word(logic [1:0] f, logic [TASK_W-1:0] t, logic [STAMP_W-1:0] s);
		int gap;
		gap = idle_on ? $urandom_range(0, WAIT_MAX) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid  <= 1'b1;
		func        <= f;
		task_id     <= t;
		cycle_stamp <= s;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		words_sent++;
		if (f == FUNC_STOP)
			stop_words++;
		if (t >= TASK_COUNT)
			ignored_words++;
		if (f == FUNC_START)
			opened_at[t] = s;
	endtask

	task automatic settle(int extra);
		item_valid <= 1'b0;
		// one edge first so the outstanding count covers the last accepted word
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_clock(logic [CLK_W-1:0] hz);
		settle(SETTLE);
		clock_hz_we    <= 1'b1;
		clock_hz_wdata <= hz;
		@(posedge clk);
		clock_hz_we <= 1'b0;
		settings_used++;
	endtask

	task automatic random_word();
		logic [TASK_W-1:0]  t;
		logic [1:0]         f;
		logic [STAMP_W-1:0] s;
		logic [STAMP_W-1:0] span;
		int                 pick;
		if ($urandom_range(0, 19) == 0)
			t = TASK_W'($urandom_range(TASK_COUNT, 255));
		else
			t = TASK_W'($urandom_range(0, TASK_COUNT - 1));
		pick = $urandom_range(0, 99);
		if (pick < 35)
			f = FUNC_START;
		else if (pick < 75)
			f = FUNC_STOP;
		else if (pick < 95)
			f = FUNC_READ;
		else
			f = FUNC_SPARE;
		s = $urandom;
		// most stops close a recorded start after a span of varied size
		if (f == FUNC_STOP && $urandom_range(0, 9) != 0) begin
			case ($urandom_range(0, 3))
				0: span = $urandom_range(0, 255);
				1: span = $urandom_range(0, 1 << 20);
				2: span = $urandom_range(0, 1 << 28);
				default: span = $urandom;
			endcase
			s = opened_at[t] + span;
		end
		offer_word(f, t, s);
	endtask

	task automatic run_random(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 39) == 0)
				idle_on = ~idle_on;
			random_word();
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		clock_hz_we    = 1'b0;
		clock_hz_wdata = '0;
		item_valid     = 1'b0;
		func           = FUNC_START;
		task_id        = '0;
		cycle_stamp    = '0;
		for (int i = 0; i < 256; i++)
			opened_at[i] = '0;
		clock_plan[0] = CLK_W'(1000000);
		clock_plan[1] = CLK_W'(1000000000);
		clock_plan[2] = '0;
		clock_plan[3] = CLK_W'(1);
		clock_plan[4] = CLK_W'(999999);
		clock_plan[5] = '1;
		clock_plan[6] = CLK_W'($urandom_range(1000000, 1000000000));
		clock_plan[7] = CLK_W'($urandom);
		clock_plan[8] = CLOCK_HZ_RESET;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed words at the reset clock
		offer_word(FUNC_STOP, 8'd0, 32'd168);
		offer_word(FUNC_READ, 8'd0, '0);
		offer_word(FUNC_READ, TASK_W'(TASK_COUNT - 1), '1);
		offer_word(FUNC_START, 8'd3, '0);
		offer_word(FUNC_STOP, 8'd3, '1);
		offer_word(FUNC_STOP, 8'd3, 32'd16800);
		offer_word(FUNC_SPARE, 8'd3, 32'h1234_5678);
		offer_word(FUNC_START, 8'd15, 32'hFFFF_0000);
		offer_word(FUNC_STOP, 8'd15, 32'h00A0_0000);
		offer_word(FUNC_START, 8'd7, 32'h5555_5555);
		offer_word(FUNC_STOP, 8'd7, 32'hAAAA_AAAA);
		offer_word(FUNC_START, TASK_W'(TASK_COUNT), '0);
		offer_word(FUNC_STOP, 8'd255, '1);
		offer_word(FUNC_READ, 8'd128, 32'hAAAA_AAAA);
		offer_word(FUNC_SPARE, 8'd200, 32'h5555_5555);
		offer_word(FUNC_STOP, 8'd15, 32'h00A0_0000);

		run_random(PHASE_WORDS);

		// long result hold-off while words keep coming, then a full drain
		hold_asks++;
		run_random(20);
		settle(0);
		run_random(20);

		for (int p = 0; p < PLAN_LEN; p++) begin
			write_clock(clock_plan[p]);
			idle_on = (p % 3 != 1);
			offer_word(FUNC_START, 8'd1, '0);
			offer_word(FUNC_STOP, 8'd1, '1);
			offer_word(FUNC_START, 8'd2, 32'd5);
			offer_word(FUNC_STOP, 8'd2, 32'd6);
			run_random(PHASE_WORDS);
		end

		settle(SETTLE);
		$display("covered %0d words (%0d stops, %0d out-of-range task numbers) over %0d clock settings",
			words_sent, stop_words, ignored_words, settings_used);
		$display("%0d result words checked, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
